@@ sv/weather_station_link_sequencer_assert.svh @@
// Assertion macros shared by the link sequencer RTL.
// Depends on nothing; included inside module bodies.
`ifndef WEATHER_STATION_LINK_SEQUENCER_ASSERT_SVH
`define WEATHER_STATION_LINK_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("link sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("link sequencer check failed");

`endif

@@ sv/wsls_pkg.sv @@
// Shared types and constants of the weather station link sequencer.
// No dependencies; imported by wsls_engine and the top level.
package wsls_pkg;

	localparam logic [4:0] MAX_NIBBLES = 5'd30;

	localparam logic [7:0] ADDR_BASE     = 8'h82;
	localparam logic [7:0] LEN_BASE      = 8'hC2;
	localparam logic [7:0] LEN_ACK_BASE  = 8'h30;
	localparam logic [7:0] SET_ACK_BASE  = 8'h04;
	localparam logic [7:0] CLR_ACK_BASE  = 8'h0C;
	localparam logic [7:0] NIB_ACK_BASE  = 8'h10;
	localparam logic [7:0] SYNC_REPLY    = 8'h02;
	localparam logic [7:0] SYNC_BYTE     = 8'h06;

	localparam logic [7:0] SETBIT_RESET  = 8'd18;
	localparam logic [7:0] CLEARBIT_RESET = 8'd50;
	localparam logic [7:0] NIBWR_RESET   = 8'd66;
	localparam logic [6:0] SYNC_LIM_RESET = 7'd100;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SYNC,
		PH_ADDR_READ,
		PH_ADDR_WRITE,
		PH_READ_LEN,
		PH_READ_DATA,
		PH_READ_SUM,
		PH_WRITE_DATA
	} phase_t;

	typedef enum logic [2:0] {
		CMD_SYNC    = 3'd0,
		CMD_READ    = 3'd1,
		CMD_WRITE   = 3'd2,
		CMD_LOAD    = 3'd3,
		CMD_RX      = 3'd4,
		CMD_TIMEOUT = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		WK_SET     = 2'd0,
		WK_CLEAR   = 2'd1,
		WK_NIBBLES = 2'd2,
		WK_INVALID = 2'd3
	} wkind_t;

	typedef enum logic [1:0] {
		KIND_TX   = 2'd0,
		KIND_DATA = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_ACK = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_BAD_SUM = 3'd3,
		ST_INVALID = 3'd4,
		ST_NO_SYNC = 3'd5,
		ST_BUSY    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CFG_SETBIT   = 2'd0,
		CFG_CLEARBIT = 2'd1,
		CFG_NIBWR    = 2'd2,
		CFG_SYNC_LIM = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] address;
		logic [4:0]  count;
		logic [1:0]  write_kind;
		logic [4:0]  nibble_index;
		logic [3:0]  nibble_value;
		logic [7:0]  rx_value;
	} item_t;

	typedef struct packed {
		logic [7:0] setbit_opcode;
		logic [7:0] clearbit_opcode;
		logic [7:0] nibble_write_opcode;
		logic [6:0] sync_attempt_limit;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] value;
		logic [2:0] status;
	} result_t;

endpackage

@@ sv/wsls_engine.sv @@
// Link state machine, transaction state and nibble buffer of the sequencer.
// Depends on wsls_pkg and weather_station_link_sequencer_assert.svh.
module wsls_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  wsls_pkg::item_t   item,
	input  wsls_pkg::cfg_t    cfg,
	output wsls_pkg::result_t res
);
	import wsls_pkg::*;

	`include "weather_station_link_sequencer_assert.svh"

	phase_t      phase_q, phase_d;
	logic [15:0] target_address_q, target_address_d;
	logic [4:0]  nibble_count_q, nibble_count_d;
	logic [4:0]  step_position_q, step_position_d;
	logic [7:0]  expected_ack_q, expected_ack_d;
	logic [7:0]  running_sum_q, running_sum_d;
	logic [6:0]  sync_attempts_q, sync_attempts_d;
	logic        sync_seen_q, sync_seen_d;
	logic [7:0]  op_base_q, op_base_d;
	logic [7:0]  ack_base_q, ack_base_d;
	logic [3:0]  nib_buf_q [32];

	logic [4:0]  step_inc;
	logic        ack_ok;
	logic [4:0]  read_bytes;
	logic        starting, busy;
	logic        rd_invalid, wr_invalid;
	logic [4:0]  wr_limit;
	logic [1:0]  addr_idx;
	logic [15:0] addr_src;
	logic [3:0]  addr_nib;
	logic [7:0]  addr_byte, addr_ack;
	logic [4:0]  nib_idx;
	logic [3:0]  nib;
	logic [7:0]  nib_byte, nib_ack;
	logic [7:0]  len_byte, len_ack;
	logic        limit_hit;

	// shared decode
	always_comb begin
		step_inc   = step_position_q + 5'd1;
		ack_ok     = (item.rx_value == expected_ack_q);
		read_bytes = 5'((6'(nibble_count_q) + 6'd1) >> 1);
		starting   = (item.cmd == CMD_SYNC) || (item.cmd == CMD_READ) ||
			(item.cmd == CMD_WRITE);
		busy       = starting && (phase_q != PH_IDLE);
		rd_invalid = (item.count == 5'd0) || (item.count > MAX_NIBBLES);
		wr_limit   = ((item.write_kind == WK_SET) || (item.write_kind == WK_CLEAR)) ?
			5'd1 : MAX_NIBBLES;
		wr_invalid = (item.write_kind == WK_INVALID) || (item.count > wr_limit);
		// address nibbles go out high nibble first
		addr_idx   = (phase_q == PH_IDLE) ? 2'd0 : step_inc[1:0];
		addr_src   = (phase_q == PH_IDLE) ? item.address : target_address_q;
		addr_nib   = 4'(addr_src >> {~addr_idx, 2'b00});
		addr_byte  = ADDR_BASE + {2'b00, addr_nib, 2'b00};
		addr_ack   = {2'b00, addr_idx, addr_nib};
		nib_idx    = (phase_q == PH_WRITE_DATA) ? step_inc : 5'd0;
		nib        = nib_buf_q[nib_idx];
		nib_byte   = op_base_q + {2'b00, nib, 2'b00};
		nib_ack    = {4'b0000, nib} + ack_base_q;
		len_byte   = LEN_BASE + {1'b0, read_bytes, 2'b00};
		len_ack    = LEN_ACK_BASE + {3'b000, read_bytes};
		limit_hit  = (sync_attempts_q >= cfg.sync_attempt_limit);
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (!busy) begin
			case (item.cmd)
				CMD_SYNC: phase_d = PH_SYNC;
				CMD_READ: if (!rd_invalid) phase_d = PH_ADDR_READ;
				CMD_WRITE: if (!wr_invalid) phase_d = PH_ADDR_WRITE;
				CMD_RX: begin
					unique case (phase_q)
						PH_ADDR_READ, PH_ADDR_WRITE: begin
							if (!ack_ok)
								phase_d = PH_IDLE;
							else if (step_inc >= 5'd4) begin
								if (phase_q == PH_ADDR_READ)
									phase_d = PH_READ_LEN;
								else if (nibble_count_q == 5'd0)
									phase_d = PH_IDLE;
								else
									phase_d = PH_WRITE_DATA;
							end
						end
						PH_READ_LEN: phase_d = ack_ok ? PH_READ_DATA : PH_IDLE;
						PH_READ_DATA: if (step_inc >= read_bytes) phase_d = PH_READ_SUM;
						PH_READ_SUM: phase_d = PH_IDLE;
						PH_WRITE_DATA: begin
							if (!ack_ok || step_inc >= nibble_count_q)
								phase_d = PH_IDLE;
						end
						default: phase_d = phase_q;
					endcase
				end
				CMD_TIMEOUT: begin
					unique case (phase_q)
						PH_IDLE: phase_d = PH_IDLE;
						PH_SYNC: if (sync_seen_q || limit_hit) phase_d = PH_IDLE;
						default: phase_d = PH_IDLE;
					endcase
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// result and datapath
	always_comb begin
		res              = '0;
		target_address_d = target_address_q;
		nibble_count_d   = nibble_count_q;
		step_position_d  = step_position_q;
		expected_ack_d   = expected_ack_q;
		running_sum_d    = running_sum_q;
		sync_attempts_d  = sync_attempts_q;
		sync_seen_d      = sync_seen_q;
		op_base_d        = op_base_q;
		ack_base_d       = ack_base_q;
		if (busy) begin
			res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0, status: ST_BUSY};
		end else begin
			case (item.cmd)
				CMD_SYNC: begin
					sync_attempts_d = 7'd1;
					sync_seen_d     = 1'b0;
					res = '{valid: 1'b1, kind: KIND_TX, value: SYNC_BYTE, status: ST_OK};
				end
				CMD_READ: begin
					if (rd_invalid) begin
						res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
							status: ST_INVALID};
					end else begin
						target_address_d = item.address;
						nibble_count_d   = item.count;
						step_position_d  = 5'd0;
						expected_ack_d   = addr_ack;
						res = '{valid: 1'b1, kind: KIND_TX, value: addr_byte, status: ST_OK};
					end
				end
				CMD_WRITE: begin
					if (wr_invalid) begin
						res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
							status: ST_INVALID};
					end else begin
						case (item.write_kind)
							WK_SET: begin
								op_base_d  = cfg.setbit_opcode;
								ack_base_d = SET_ACK_BASE;
							end
							WK_CLEAR: begin
								op_base_d  = cfg.clearbit_opcode;
								ack_base_d = CLR_ACK_BASE;
							end
							default: begin
								op_base_d  = cfg.nibble_write_opcode;
								ack_base_d = NIB_ACK_BASE;
							end
						endcase
						target_address_d = item.address;
						nibble_count_d   = item.count;
						step_position_d  = 5'd0;
						expected_ack_d   = addr_ack;
						res = '{valid: 1'b1, kind: KIND_TX, value: addr_byte, status: ST_OK};
					end
				end
				CMD_RX: begin
					case (phase_q)
						PH_SYNC: if (item.rx_value == SYNC_REPLY) sync_seen_d = 1'b1;
						PH_ADDR_READ, PH_ADDR_WRITE: begin
							if (!ack_ok) begin
								res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
									status: ST_BAD_ACK};
							end else begin
								step_position_d = step_inc;
								if (step_inc < 5'd4) begin
									expected_ack_d = addr_ack;
									res = '{valid: 1'b1, kind: KIND_TX, value: addr_byte,
										status: ST_OK};
								end else if (phase_q == PH_ADDR_READ) begin
									expected_ack_d = len_ack;
									res = '{valid: 1'b1, kind: KIND_TX, value: len_byte,
										status: ST_OK};
								end else begin
									step_position_d = 5'd0;
									if (nibble_count_q == 5'd0) begin
										res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
											status: ST_OK};
									end else begin
										expected_ack_d = nib_ack;
										res = '{valid: 1'b1, kind: KIND_TX, value: nib_byte,
											status: ST_OK};
									end
								end
							end
						end
						PH_READ_LEN: begin
							if (!ack_ok) begin
								res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
									status: ST_BAD_ACK};
							end else begin
								step_position_d = 5'd0;
								running_sum_d   = 8'd0;
							end
						end
						PH_READ_DATA: begin
							running_sum_d   = running_sum_q + item.rx_value;
							step_position_d = step_inc;
							res = '{valid: 1'b1, kind: KIND_DATA, value: item.rx_value,
								status: ST_OK};
						end
						PH_READ_SUM: begin
							res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
								status: (item.rx_value == running_sum_q) ? ST_OK : ST_BAD_SUM};
						end
						PH_WRITE_DATA: begin
							if (!ack_ok) begin
								res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
									status: ST_BAD_ACK};
							end else begin
								step_position_d = step_inc;
								if (step_inc >= nibble_count_q) begin
									res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
										status: ST_OK};
								end else begin
									expected_ack_d = nib_ack;
									res = '{valid: 1'b1, kind: KIND_TX, value: nib_byte,
										status: ST_OK};
								end
							end
						end
						default: res = '0;
					endcase
				end
				CMD_TIMEOUT: begin
					case (phase_q)
						PH_IDLE: res = '0;
						PH_SYNC: begin
							if (sync_seen_q) begin
								res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
									status: ST_OK};
							end else if (limit_hit) begin
								res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
									status: ST_NO_SYNC};
							end else begin
								sync_attempts_d = sync_attempts_q + 7'd1;
								sync_seen_d     = 1'b0;
								res = '{valid: 1'b1, kind: KIND_TX, value: SYNC_BYTE,
									status: ST_OK};
							end
						end
						default: begin
							res = '{valid: 1'b1, kind: KIND_DONE, value: 8'd0,
								status: ST_TIMEOUT};
						end
					endcase
				end
				default: res = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			target_address_q <= '0;
			nibble_count_q   <= '0;
			step_position_q  <= '0;
			expected_ack_q   <= '0;
			running_sum_q    <= '0;
			sync_attempts_q  <= '0;
			sync_seen_q      <= 1'b0;
			op_base_q        <= '0;
			ack_base_q       <= '0;
		end else if (step_en) begin
			phase_q          <= phase_d;
			target_address_q <= target_address_d;
			nibble_count_q   <= nibble_count_d;
			step_position_q  <= step_position_d;
			expected_ack_q   <= expected_ack_d;
			running_sum_q    <= running_sum_d;
			sync_attempts_q  <= sync_attempts_d;
			sync_seen_q      <= sync_seen_d;
			op_base_q        <= op_base_d;
			ack_base_q       <= ack_base_d;
		end
	end

	// nibble buffer, loadable at any time
	always_ff @(posedge clk) begin
		if (step_en && item.cmd == CMD_LOAD)
			nib_buf_q[item.nibble_index] <= item.nibble_value;
	end

	`WSLS_ASSERT_NEXT(a_done_to_idle, clk, arst_n,
		step_en && res.valid && res.kind == KIND_DONE && res.status != ST_BUSY,
		phase_q == PH_IDLE)
	`WSLS_ASSERT_NOW(a_data_in_read, clk, arst_n,
		step_en && res.valid && res.kind == KIND_DATA, phase_q == PH_READ_DATA)

endmodule

@@ sv/weather_station_link_sequencer.sv @@
// Top level of the weather station link sequencer: handshakes, registers.
// Depends on wsls_pkg, wsls_engine and weather_station_link_sequencer_assert.svh.

// Takes one event per clock (command, received byte or timeout) and gives at
// most one result per event: a byte to transmit, a read data byte, or a
// completion status. An accepted event lands in an input register and is
// processed by the link state machine once the output register is empty or
// being taken, and its result is written into the output register. Throughput
// is one event per cycle; the input side stalls only while both the input
// register and the output register are full and the output is not being taken.
// The configuration port is always ready; write it only while the link is idle.
module weather_station_link_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] address,
	input  logic [4:0]  count,
	input  logic [1:0]  write_kind,
	input  logic [4:0]  nibble_index,
	input  logic [3:0]  nibble_value,
	input  logic [7:0]  rx_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import wsls_pkg::*;

	`include "weather_station_link_sequencer_assert.svh"

	logic    valid_s1;
	item_t   item_s1;
	cfg_t    cfg_q;
	result_t res;
	logic    adv;
	logic    out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] value_q;
	logic [2:0] status_q;

	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= '{cmd: cmd, address: address, count: count,
				write_kind: write_kind, nibble_index: nibble_index,
				nibble_value: nibble_value, rx_value: rx_value};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{setbit_opcode: SETBIT_RESET, clearbit_opcode: CLEARBIT_RESET,
				nibble_write_opcode: NIBWR_RESET, sync_attempt_limit: SYNC_LIM_RESET};
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SETBIT:   cfg_q.setbit_opcode       <= cfg_data;
				CFG_CLEARBIT: cfg_q.clearbit_opcode     <= cfg_data;
				CFG_NIBWR:    cfg_q.nibble_write_opcode <= cfg_data;
				CFG_SYNC_LIM: cfg_q.sync_attempt_limit  <= cfg_data[6:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	wsls_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q   <= res.kind;
			value_q  <= res.value;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign status    = status_q;

	`WSLS_ASSERT_NOW(a_stall_cause, clk, arst_n,
		!in_ready, valid_s1 && out_valid_q && !out_ready)
	`WSLS_ASSERT_NOW(a_done_no_value, clk, arst_n,
		out_valid && kind == KIND_DONE, value == 8'd0)
	`WSLS_ASSERT_NOW(a_byte_status_ok, clk, arst_n,
		out_valid && kind != KIND_DONE, status == ST_OK)

endmodule

@@ bench/wsls_link_tracker_pkg.sv @@
// Transaction tracker for the link sequencer bench: predicts every output
// from accepted events and register writes, then checks the DUT outputs.
// Depends on wsls_pkg for the command, kind, status and phase codes.
package wsls_link_tracker_pkg;
	import wsls_pkg::*;

	typedef struct {
		kind_t      kind;
		logic [7:0] value;
		status_t    status;
	} link_out_t;

	class link_tracker;
		phase_t      stage;
		logic [15:0] addr_reg;
		logic [4:0]  len_reg;
		logic [4:0]  step;
		logic [7:0]  ack_due;
		logic [7:0]  sum_acc;
		logic [6:0]  tries;
		bit          reply_seen;
		logic [7:0]  opcode;
		logic [7:0]  ack_off;
		logic [3:0]  nib_store [32];

		logic [7:0]  cfg_set;
		logic [7:0]  cfg_clr;
		logic [7:0]  cfg_nib;
		logic [6:0]  cfg_tries;

		link_out_t   awaited [$];
		int unsigned errors;
		int unsigned live_events;
		int unsigned reg_writes;
		int unsigned tx_seen;
		int unsigned data_seen;
		int unsigned done_seen;

		function new();
			stage = PH_IDLE;
			addr_reg = '0;
			len_reg = '0;
			step = '0;
			ack_due = '0;
			sum_acc = '0;
			tries = '0;
			reply_seen = 0;
			opcode = '0;
			ack_off = '0;
			foreach (nib_store[i]) nib_store[i] = '0;
			cfg_set = SETBIT_RESET;
			cfg_clr = CLEARBIT_RESET;
			cfg_nib = NIBWR_RESET;
			cfg_tries = SYNC_LIM_RESET;
			errors = 0;
			live_events = 0;
			reg_writes = 0;
			tx_seen = 0;
			data_seen = 0;
			done_seen = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] data);
			reg_writes++;
			case (idx)
				CFG_SETBIT:   cfg_set = data;
				CFG_CLEARBIT: cfg_clr = data;
				CFG_NIBWR:    cfg_nib = data;
				CFG_SYNC_LIM: cfg_tries = data[6:0];
				default: ;
			endcase
		endfunction

		function void queue_out(kind_t k, logic [7:0] v, status_t s);
			link_out_t e;
			e.kind = k;
			e.value = v;
			e.status = s;
			awaited.push_back(e);
		endfunction

		function void complete(status_t s);
			stage = PH_IDLE;
			queue_out(KIND_DONE, 8'h00, s);
		endfunction

		// address bytes go out high nibble first; ack carries the byte index
		function void emit_addr();
			logic [3:0] n;
			n = addr_reg[4 * (3 - int'(step[1:0])) +: 4];
			ack_due = {2'b00, step[1:0], n};
			queue_out(KIND_TX, ADDR_BASE + {2'b00, n, 2'b00}, ST_OK);
		endfunction

		// buffer is read at send time, so late loads are picked up
		function void emit_nib();
			logic [3:0] n;
			n = nib_store[step];
			ack_due = ack_off + n;
			queue_out(KIND_TX, opcode + {2'b00, n, 2'b00}, ST_OK);
		endfunction

		function int unsigned data_bytes();
			return (len_reg + 1) >> 1;
		endfunction

		function void take_byte(logic [7:0] rx);
			int unsigned b;
			case (stage)
				PH_SYNC: begin
					if (rx == SYNC_REPLY) reply_seen = 1;
				end
				PH_ADDR_READ, PH_ADDR_WRITE: begin
					if (rx != ack_due) begin
						complete(ST_BAD_ACK);
					end else begin
						step++;
						if (step < 4) begin
							emit_addr();
						end else if (stage == PH_ADDR_READ) begin
							b = data_bytes();
							ack_due = LEN_ACK_BASE + 8'(b);
							stage = PH_READ_LEN;
							queue_out(KIND_TX, LEN_BASE + 8'(4 * b), ST_OK);
						end else begin
							step = '0;
							if (len_reg == 0) begin
								complete(ST_OK);
							end else begin
								stage = PH_WRITE_DATA;
								emit_nib();
							end
						end
					end
				end
				PH_READ_LEN: begin
					if (rx != ack_due) begin
						complete(ST_BAD_ACK);
					end else begin
						stage = PH_READ_DATA;
						step = '0;
						sum_acc = '0;
					end
				end
				PH_READ_DATA: begin
					sum_acc = sum_acc + rx;
					step++;
					if (step >= data_bytes()) stage = PH_READ_SUM;
					queue_out(KIND_DATA, rx, ST_OK);
				end
				PH_READ_SUM: begin
					complete((rx == sum_acc) ? ST_OK : ST_BAD_SUM);
				end
				PH_WRITE_DATA: begin
					if (rx != ack_due) begin
						complete(ST_BAD_ACK);
					end else begin
						step++;
						if (step >= len_reg) complete(ST_OK);
						else emit_nib();
					end
				end
				default: ;
			endcase
		endfunction

		function void take_timeout();
			if (stage != PH_SYNC) begin
				complete(ST_TIMEOUT);
			end else if (reply_seen) begin
				complete(ST_OK);
			end else if (tries >= cfg_tries) begin
				complete(ST_NO_SYNC);
			end else begin
				tries++;
				reply_seen = 0;
				queue_out(KIND_TX, SYNC_BYTE, ST_OK);
			end
		endfunction

		function void note_event(item_t it);
			if (it.cmd <= CMD_WRITE && stage != PH_IDLE) begin
				live_events++;
				queue_out(KIND_DONE, 8'h00, ST_BUSY);
				return;
			end
			case (it.cmd)
				CMD_SYNC: begin
					live_events++;
					tries = 7'd1;
					reply_seen = 0;
					stage = PH_SYNC;
					queue_out(KIND_TX, SYNC_BYTE, ST_OK);
				end
				CMD_READ: begin
					live_events++;
					if (it.count == 0 || it.count > MAX_NIBBLES) begin
						queue_out(KIND_DONE, 8'h00, ST_INVALID);
					end else begin
						addr_reg = it.address;
						len_reg = it.count;
						step = '0;
						stage = PH_ADDR_READ;
						emit_addr();
					end
				end
				CMD_WRITE: begin
					live_events++;
					if (it.write_kind == WK_INVALID ||
					    it.count > ((it.write_kind == WK_NIBBLES) ? MAX_NIBBLES : 5'd1)) begin
						queue_out(KIND_DONE, 8'h00, ST_INVALID);
					end else begin
						// opcode is captured here; later register writes do not apply
						case (it.write_kind)
							WK_SET: begin
								opcode = cfg_set;
								ack_off = SET_ACK_BASE;
							end
							WK_CLEAR: begin
								opcode = cfg_clr;
								ack_off = CLR_ACK_BASE;
							end
							default: begin
								opcode = cfg_nib;
								ack_off = NIB_ACK_BASE;
							end
						endcase
						addr_reg = it.address;
						len_reg = it.count;
						step = '0;
						stage = PH_ADDR_WRITE;
						emit_addr();
					end
				end
				CMD_LOAD: begin
					live_events++;
					nib_store[it.nibble_index] = it.nibble_value;
				end
				CMD_RX: begin
					if (stage != PH_IDLE) begin
						live_events++;
						take_byte(it.rx_value);
					end
				end
				CMD_TIMEOUT: begin
					if (stage != PH_IDLE) begin
						live_events++;
						take_timeout();
					end
				end
				default: ;
			endcase
		endfunction

		function void check_output(logic [1:0] k, logic [7:0] v, logic [2:0] s);
			link_out_t e;
			if (awaited.size() == 0) begin
				errors++;
				$error("output with nothing pending: kind %0d value 0x%02h status %0d",
					k, v, s);
				return;
			end
			e = awaited.pop_front();
			case (e.kind)
				KIND_TX:   tx_seen++;
				KIND_DATA: data_seen++;
				default:   done_seen++;
			endcase
			if (k !== e.kind) begin
				errors++;
				$error("kind: expected %0d, got %0d", e.kind, k);
			end
			if (v !== e.value) begin
				errors++;
				$error("value: expected 0x%02h, got 0x%02h", e.value, v);
			end
			if (s !== e.status) begin
				errors++;
				$error("status: expected %0d, got %0d", e.status, s);
			end
		endfunction

		function void close_out();
			foreach (awaited[i]) begin
				errors++;
				$error("missing output: kind %0d value 0x%02h status %0d",
					awaited[i].kind, awaited[i].value, awaited[i].status);
			end
		endfunction
	endclass

endpackage

@@ bench/weather_station_link_sequencer_test.sv @@
// Self-checking bench for weather_station_link_sequencer: directed corner
// transactions, then random sync/read/write traffic over several register sets.
// Depends on wsls_pkg and wsls_link_tracker_pkg.
module weather_station_link_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wsls_pkg::*;
	import wsls_link_tracker_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	item_t       ev = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic [2:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	link_tracker tracker = new();
	bit          loaded [32];
	bit          gaps_on = 1'b1;
	int unsigned burst_left = 0;
	int unsigned rx_cycle = 0;
	int unsigned sync_pct = 30;
	int unsigned n_sync = 0;
	int unsigned n_read = 0;
	int unsigned n_write = 0;

	weather_station_link_sequencer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (ev.cmd),
		.address      (ev.address),
		.count        (ev.count),
		.write_kind   (ev.write_kind),
		.nibble_index (ev.nibble_index),
		.nibble_value (ev.nibble_value),
		.rx_value     (ev.rx_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.value        (value),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver back-pressure cycles through free-running, random and sparse modes
	always @(negedge clk) begin
		rx_cycle++;
		case ((rx_cycle / 256) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ((rx_cycle % 9) < 3);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// outputs are checked before the same-edge input is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) tracker.check_output(kind, value, status);
			if (in_valid && in_ready) tracker.note_event(ev);
			if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
		end
	end

	function automatic item_t fresh(logic [2:0] c);
		item_t it;
		it.cmd = c;
		it.address = 16'($urandom);
		it.count = 5'($urandom);
		it.write_kind = 2'($urandom);
		it.nibble_index = 5'($urandom);
		it.nibble_value = 4'($urandom);
		it.rx_value = 8'($urandom);
		return it;
	endfunction

	function automatic logic [7:0] spoil(logic [7:0] v, int unsigned odds);
		if ($urandom_range(1, odds) == 1) return v ^ 8'($urandom_range(1, 255));
		return v;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic issue(item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gaps_on && gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		ev = it;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// hold off until every pending output is out and the pipeline has drained
	task automatic settle();
		int unsigned waited;
		waited = 0;
		in_valid = 1'b0;
		while (tracker.awaited.size() != 0 && waited < 50000) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [7:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_regs(logic [7:0] s, logic [7:0] c, logic [7:0] n, logic [7:0] l);
		write_reg(CFG_SETBIT, s);
		write_reg(CFG_CLEARBIT, c);
		write_reg(CFG_NIBWR, n);
		write_reg(CFG_SYNC_LIM, l);
	endtask

	task automatic load(int unsigned idx, logic [3:0] v);
		item_t it;
		it = fresh(CMD_LOAD);
		it.nibble_index = 5'(idx);
		it.nibble_value = v;
		issue(it);
		loaded[idx] = 1'b1;
	endtask

	task automatic byte_in(logic [7:0] b);
		item_t it;
		it = fresh(CMD_RX);
		it.rx_value = b;
		issue(it);
	endtask

	task automatic tick_out();
		issue(fresh(CMD_TIMEOUT));
	endtask

	task automatic start_read(logic [15:0] a, logic [4:0] n);
		item_t it;
		it = fresh(CMD_READ);
		it.address = a;
		it.count = n;
		issue(it);
	endtask

	task automatic start_write(wkind_t k, logic [15:0] a, logic [4:0] n);
		item_t it;
		it = fresh(CMD_WRITE);
		it.write_kind = k;
		it.address = a;
		it.count = n;
		issue(it);
	endtask

	// one event in reply to the transaction in progress, with some noise mixed in
	task automatic answer();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			tick_out();
		end else if (r < 5) begin
			issue(fresh(3'($urandom_range(CMD_SYNC, CMD_WRITE))));
		end else if (r < 8) begin
			issue(fresh(3'($urandom_range(6, 7))));
		end else if (r < 12) begin
			load($urandom_range(0, 31), 4'($urandom));
		end else begin
			case (tracker.stage)
				PH_SYNC: begin
					if ($urandom_range(0, 2) == 0) tick_out();
					else if ($urandom_range(0, 99) < sync_pct) byte_in(SYNC_REPLY);
					else byte_in(8'($urandom));
				end
				PH_READ_DATA: byte_in(8'($urandom));
				PH_READ_SUM:  byte_in(spoil(tracker.sum_acc, 8));
				default:      byte_in(spoil(tracker.ack_due, 30));
			endcase
		end
	endtask

	task automatic run_random_txn();
		int unsigned r;
		int unsigned n;
		bit          bad;
		wkind_t      k;
		r = $urandom_range(0, 99);
		bad = ($urandom_range(0, 19) == 0);
		if (r < 20) begin
			r = $urandom_range(0, 5);
			sync_pct = (r == 0) ? 0 : ((r < 4) ? 30 : 70);
			n_sync++;
			issue(fresh(CMD_SYNC));
		end else if (r < 55) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 4);
			if (bad) n = $urandom_range(0, 1) ? 0 : 31;
			n_read++;
			start_read(16'($urandom), 5'(n));
		end else if (r < 90) begin
			k = wkind_t'($urandom_range(0, 2));
			if (k == WK_NIBBLES)
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 4);
			else
				n = $urandom_range(0, 1);
			if (bad) begin
				case ($urandom_range(0, 2))
					0: begin
						k = WK_INVALID;
						n = $urandom_range(0, 31);
					end
					1: begin
						k = wkind_t'($urandom_range(0, 1));
						n = $urandom_range(2, 31);
					end
					default: begin
						k = WK_NIBBLES;
						n = 31;
					end
				endcase
			end else begin
				// every slot the write will read must hold a loaded nibble
				for (int i = 0; i < n; i++)
					if (!loaded[i] || $urandom_range(0, 3) == 0) load(i, 4'($urandom));
			end
			n_write++;
			start_write(k, 16'($urandom), 5'(n));
		end else begin
			case ($urandom_range(0, 3))
				0: byte_in(8'($urandom));
				1: tick_out();
				2: issue(fresh(3'($urandom_range(6, 7))));
				default: load($urandom_range(0, 31), 4'($urandom));
			endcase
		end
		while (tracker.stage != PH_IDLE) answer();
	endtask

	initial begin
		int unsigned target;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sync with a start arriving while busy, then stray events in idle
		issue(fresh(CMD_SYNC));
		start_read(16'hFFFF, 5'd1);
		byte_in(SYNC_REPLY);
		tick_out();
		tick_out();
		byte_in(8'hFF);
		issue(fresh(3'd7));

		// malformed requests
		start_read(16'h0000, 5'd0);
		start_read(16'hFFFF, 5'd31);
		start_write(WK_INVALID, 16'h0000, 5'd0);
		start_write(WK_SET, 16'h0000, 5'd2);
		start_write(WK_NIBBLES, 16'h0000, 5'd31);

		// set-bit write: opcode changes mid-transaction, slot reloaded before send
		load(0, 4'hF);
		start_write(WK_SET, 16'hFFFF, 5'd1);
		repeat (3) byte_in(tracker.ack_due);
		settle();
		write_reg(CFG_SETBIT, 8'hAA);
		load(0, 4'h0);
		byte_in(tracker.ack_due);
		byte_in(tracker.ack_due);

		// timeout inside a read, then an empty write
		start_read(16'h0000, 5'd30);
		tick_out();
		start_write(WK_NIBBLES, 16'h8421, 5'd0);
		repeat (4) byte_in(tracker.ack_due);

		// sync limit of zero gives up on the first timeout
		settle();
		write_reg(CFG_SYNC_LIM, 8'h00);
		issue(fresh(CMD_SYNC));
		tick_out();

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: apply_regs(SETBIT_RESET, CLEARBIT_RESET, NIBWR_RESET, {1'b0, SYNC_LIM_RESET});
				1: apply_regs(8'h00, 8'h00, 8'h00, 8'h80);
				2: apply_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
				default: apply_regs(8'($urandom), 8'($urandom), 8'($urandom),
					{$urandom_range(0, 1) == 1, 7'($urandom_range(1, 6))});
			endcase
			gaps_on = (ph != 3);
			target = 30 + (ph + 1) * 178;
			while (tracker.live_events < target) run_random_txn();
		end

		settle();
		tracker.close_out();
		$display("Covered %0d link events: %0d sync, %0d read, %0d write starts, %0d register writes",
			tracker.live_events, n_sync, n_read, n_write, tracker.reg_writes);
		$display("Checked %0d tx bytes, %0d read data bytes, %0d completions",
			tracker.tx_seen, tracker.data_seen, tracker.done_seen);
		if (tracker.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
